// ===== design/led_ring_effect_generator_macros.svh =====
// Assertion helpers for the LED ring effect generator
`ifndef LED_RING_EFFECT_GENERATOR_MACROS_SVH
`define LED_RING_EFFECT_GENERATOR_MACROS_SVH
// Implication checked on every clock edge outside reset
`define LREG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define LREG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/lreg_pkg.sv =====
// ----------------------------------------------------------------------------
// lreg_pkg
// Shared types and constants for the LED ring effect generator.
// ----------------------------------------------------------------------------
`default_nettype none
package lreg_pkg;
    localparam int MAX_PIXELS = 8;

    localparam logic [3:0] MODE_OFF       = 4'd0;
    localparam logic [3:0] MODE_SOLID     = 4'd1;
    localparam logic [3:0] MODE_BREATHING = 4'd2;
    localparam logic [3:0] MODE_CHASE     = 4'd3;
    localparam logic [3:0] MODE_RAINBOW   = 4'd4;
    localparam logic [3:0] MODE_STROBE    = 4'd5;
    localparam logic [3:0] MODE_SCANNER   = 4'd6;
    localparam logic [3:0] MODE_SPARKLE   = 4'd7;
    localparam logic [3:0] MODE_WIPE      = 4'd8;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_COLOR  = 2'd1;
    localparam logic [1:0] REG_BRIGHT = 2'd2;
    localparam logic [1:0] REG_COUNT  = 2'd3;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_APPLY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic       start;      // latch frame inputs, begin setup
        logic       setup_step; // advance setup sequence
        logic       pix_step;   // compute current pixel
        logic       pix_next;   // advance pixel index
    } lreg_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       setup_done;
        logic       emit;       // frame produces pixels
        logic       last;       // current pixel is the final one
    } lreg_status_t;
endpackage
`default_nettype wire

// ===== design/lreg_datapath.sv =====
// ----------------------------------------------------------------------------
// lreg_datapath
// Frame counter, gamma scaling, effect arithmetic and per-pixel color.
// ----------------------------------------------------------------------------
`default_nettype none
module lreg_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_en,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [23:0]          cfg_data,
    input  wire logic                 in_opcode,
    input  wire logic [31:0]          in_random,
    input  wire lreg_pkg::lreg_cmd_t  cmd,
    output lreg_pkg::lreg_status_t    status,
    output logic [2:0]                pix_index,
    output logic [7:0]                pix_red,
    output logic [7:0]                pix_green,
    output logic [7:0]                pix_blue
);
    import lreg_pkg::*;

    logic [3:0]  mode_reg;
    logic [23:0] color_reg;
    logic [8:0]  bright_reg;
    logic [3:0]  count_reg;
    logic [31:0] phase_reg, phase_next;

    logic        apply_reg;
    logic [31:0] rnd_reg;
    logic [17:0] bsq_reg;      // b^2
    logic [26:0] bcube_reg;    // b^3
    logic [7:0]  cr_reg, cg_reg, cb_reg, v_reg;
    logic [7:0]  s_reg;
    logic [3:0]  n_reg;
    logic [4:0]  modn_reg;     // reduction remainder
    logic [31:0] quo_reg;      // phase quotient by the mode's step length
    logic [63:0] mprod_reg;    // reciprocal product
    logic [3:0]  head_reg;
    logic [4:0]  step_reg;
    logic [2:0]  idx_reg;
    logic [7:0]  hbase_reg;
    logic [8:0]  hoff_reg;     // i*256/n, integer part
    logic [3:0]  hfrac_reg;    // i*256/n, remainder part
    logic [7:0]  r_reg, g_reg, b_reg;
    logic        setup_done_reg;

    // gamma product for one channel
    function automatic logic [7:0] gsc(input logic [7:0] c, input logic [26:0] k);
        logic [34:0] p;
        begin
            p = 35'(c) * 35'(k);
            return p[31:24];
        end
    endfunction

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] q;
        begin
            q = (17'(x) + 17'(x >> 8) + 17'd1) >> 8;
            return q[7:0];
        end
    endfunction

    logic [8:0] bclamp;
    assign bclamp = (bright_reg > 9'd256) ? 9'd256 : bright_reg;

    always_comb
    begin
        phase_next = (cmd.start && in_opcode) ? 32'd1 : phase_reg + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SOLID;
            color_reg  <= '0;
            bright_reg <= 9'd77;
            count_reg  <= 4'd8;
            phase_reg  <= '0;
        end
        else
        begin
            if (cfg_en)
            begin
                unique case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[3:0];
                    REG_COLOR:  color_reg  <= cfg_data;
                    REG_BRIGHT: bright_reg <= cfg_data[8:0];
                    REG_COUNT:  count_reg  <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (cmd.start)
                phase_reg <= phase_next;
        end
    end

    // reciprocal operands: phase/60 as (phase/4)/15, phase/3 and phase/6 from one product
    logic [31:0] mul_a, mul_k;
    always_comb
    begin
        if (mode_reg == MODE_BREATHING)
        begin
            mul_a = phase_reg >> 2;
            mul_k = 32'h88888889;
        end
        else
        begin
            mul_a = phase_reg;
            mul_k = 32'hAAAAAAAB;
        end
    end

    // second reduction modulus
    logic [4:0] m2;
    always_comb
    begin
        unique case (mode_reg)
            MODE_CHASE:   m2 = {1'b0, n_reg};
            MODE_SCANNER: m2 = 5'({n_reg - 4'd1, 1'b0});
            MODE_WIPE:    m2 = {n_reg, 1'b0};
            default:      m2 = 5'd1;
        endcase
    end

    // hue spacing 256/n as integer step and remainder
    logic [8:0] hstep;
    logic [3:0] hrem;
    always_comb
    begin
        unique case (n_reg)
            4'd1:    begin hstep = 9'd256; hrem = 4'd0; end
            4'd2:    begin hstep = 9'd128; hrem = 4'd0; end
            4'd3:    begin hstep = 9'd85;  hrem = 4'd1; end
            4'd4:    begin hstep = 9'd64;  hrem = 4'd0; end
            4'd5:    begin hstep = 9'd51;  hrem = 4'd1; end
            4'd6:    begin hstep = 9'd42;  hrem = 4'd4; end
            4'd7:    begin hstep = 9'd36;  hrem = 4'd4; end
            4'd8:    begin hstep = 9'd32;  hrem = 4'd0; end
            default: begin hstep = 9'd0;   hrem = 4'd0; end
        endcase
    end

    logic [4:0] fsum;
    assign fsum = 5'(hfrac_reg) + 5'(hrem);

    // serial remainder of the quotient by m2, one bit per cycle (MSB first)
    logic [5:0] rem_sh;
    logic [5:0] rem_nx;
    assign rem_sh = {modn_reg, q2_reg[31]};
    assign rem_nx = (rem_sh >= 6'(m2)) ? rem_sh - 6'(m2) : rem_sh;

    // pixel effect
    logic [3:0]  ipix;
    logic [3:0]  pdist;
    logic        lit;
    logic [7:0]  hue;
    logic [2:0]  region;
    logic [7:0]  rem6;
    logic [7:0]  qv, tv;
    logic [15:0] prod_r, prod_g, prod_b;
    always_comb
    begin
        ipix = {1'b0, idx_reg};
        pdist = (ipix > head_reg) ? ipix - head_reg : head_reg - ipix;
        lit = (step_reg < {1'b0, n_reg}) ? (ipix <= step_reg[3:0])
            : (5'(ipix) > step_reg - {1'b0, n_reg});
        hue = hbase_reg + hoff_reg[7:0];
        if (hue < 8'd43) region = 3'd0;
        else if (hue < 8'd86) region = 3'd1;
        else if (hue < 8'd129) region = 3'd2;
        else if (hue < 8'd172) region = 3'd3;
        else if (hue < 8'd215) region = 3'd4;
        else region = 3'd5;
        rem6 = 8'((hue - 8'(region) * 8'd43) * 8'd6);
        qv = div255(16'(v_reg) * 16'(8'd255 - rem6));
        tv = div255(16'(v_reg) * 16'(rem6));
        prod_r = 16'(cr_reg) * 16'(s_reg);
        prod_g = 16'(cg_reg) * 16'(s_reg);
        prod_b = 16'(cb_reg) * 16'(s_reg);
    end

    logic [7:0] nr, ng, nb;
    always_comb
    begin
        nr = cr_reg; ng = cg_reg; nb = cb_reg;
        unique case (mode_reg)
            MODE_OFF:
            begin
                nr = '0; ng = '0; nb = '0;
            end
            MODE_BREATHING:
            begin
                nr = div255(prod_r); ng = div255(prod_g); nb = div255(prod_b);
            end
            MODE_CHASE:
                if (ipix != head_reg)
                begin
                    nr = cr_reg >> 3; ng = cg_reg >> 3; nb = cb_reg >> 3;
                end
            MODE_RAINBOW:
                unique case (region)
                    3'd0: begin nr = v_reg; ng = tv;    nb = '0;    end
                    3'd1: begin nr = qv;    ng = v_reg; nb = '0;    end
                    3'd2: begin nr = '0;    ng = v_reg; nb = tv;    end
                    3'd3: begin nr = '0;    ng = qv;    nb = v_reg; end
                    3'd4: begin nr = tv;    ng = '0;    nb = v_reg; end
                    default: begin nr = v_reg; ng = '0; nb = qv;    end
                endcase
            MODE_STROBE:
                if (!(step_reg < 5'd2))
                begin
                    nr = '0; ng = '0; nb = '0;
                end
            MODE_SCANNER:
                if (pdist == 4'd1)
                begin
                    nr = cr_reg >> 2; ng = cg_reg >> 2; nb = cb_reg >> 2;
                end
                else if (pdist != 4'd0)
                begin
                    nr = '0; ng = '0; nb = '0;
                end
            MODE_SPARKLE:
                if (!(rnd_reg[3:0] < 4'd2))
                begin
                    nr = '0; ng = '0; nb = '0;
                end
            MODE_WIPE:
                if (!lit)
                begin
                    nr = '0; ng = '0; nb = '0;
                end
            default: ;
        endcase
    end

    logic emit_c;
    always_comb
    begin
        if (n_reg == 4'd0)
            emit_c = 1'b0;
        else if (mode_reg == MODE_SCANNER)
            emit_c = n_reg >= 4'd2;
        else if (mode_reg == MODE_OFF || mode_reg == MODE_SOLID || mode_reg > MODE_WIPE)
            emit_c = apply_reg;
        else
            emit_c = 1'b1;
    end

    // setup: 0 b^2, 1 b^3, 2 colors + reciprocal product, 3 quotient,
    // 4 phase remainder + load, 5..35 remainder by m2, 36 finish
    logic [6:0]  cnt_reg;
    logic [31:0] q2_reg;
    logic [5:0]  prem_reg;  // phase mod 60 (breathing) or mod 6 (strobe)

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            setup_done_reg <= 1'b0;
        else if (cmd.start)
            setup_done_reg <= 1'b0;
        else if (cmd.setup_step && cnt_reg == 7'd36)
            setup_done_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            apply_reg <= in_opcode;
            rnd_reg   <= in_random;
            cnt_reg   <= '0;
            n_reg     <= (count_reg > 4'(MAX_PIXELS)) ? 4'(MAX_PIXELS) : count_reg;
            idx_reg   <= '0;
            hoff_reg  <= '0;
            hfrac_reg <= '0;
        end
        else if (cmd.setup_step)
        begin
            cnt_reg <= cnt_reg + 7'd1;
            if (cnt_reg == 7'd0)
                bsq_reg <= 18'(bclamp) * 18'(bclamp);
            else if (cnt_reg == 7'd1)
                bcube_reg <= 27'(bsq_reg * 27'(bclamp));
            else if (cnt_reg == 7'd2)
            begin
                cr_reg    <= gsc(color_reg[23:16], bcube_reg);
                cg_reg    <= gsc(color_reg[15:8], bcube_reg);
                cb_reg    <= gsc(color_reg[7:0], bcube_reg);
                v_reg     <= gsc(8'hFF, bcube_reg);
                mprod_reg <= 64'(mul_a) * 64'(mul_k);
            end
            else if (cnt_reg == 7'd3)
            begin
                unique case (mode_reg)
                    MODE_BREATHING: quo_reg <= 32'(mprod_reg >> 35);
                    MODE_STROBE:    quo_reg <= 32'(mprod_reg >> 34);
                    MODE_SCANNER:   quo_reg <= 32'(mprod_reg >> 33);
                    MODE_RAINBOW:   quo_reg <= phase_reg >> 1;
                    default:        quo_reg <= phase_reg >> 2;
                endcase
            end
            else if (cnt_reg == 7'd4)
            begin
                prem_reg  <= 6'(phase_reg - quo_reg
                    * ((mode_reg == MODE_BREATHING) ? 32'd60 : 32'd6));
                q2_reg    <= quo_reg;
                hbase_reg <= quo_reg[7:0];
                modn_reg  <= '0;
            end
            else if (cnt_reg < 7'd36)
            begin
                q2_reg   <= {q2_reg[30:0], 1'b0};
                modn_reg <= 5'(rem_nx);
            end
            else
            begin
                // last remainder bit and final interpretation
                step_reg <= (mode_reg == MODE_STROBE) ? 5'(prem_reg) : rem_nx[4:0];
                head_reg <= (mode_reg == MODE_SCANNER && rem_nx[4:0] >= {1'b0, n_reg})
                    ? 4'(m2 - rem_nx[4:0]) : rem_nx[3:0];
                s_reg <= (prem_reg < 6'd30) ? 8'((10'(prem_reg) * 10'd17) >> 1)
                    : 8'((10'(6'd59 - prem_reg) * 10'd17) >> 1);
            end
        end
        else if (cmd.pix_step)
        begin
            r_reg <= nr;
            g_reg <= ng;
            b_reg <= nb;
        end
        else if (cmd.pix_next)
        begin
            idx_reg <= idx_reg + 3'd1;
            rnd_reg <= rnd_reg >> 4;
            // carry the fraction so the offset stays exactly i*256/n
            if (fsum >= 5'(n_reg))
            begin
                hfrac_reg <= 4'(fsum - 5'(n_reg));
                hoff_reg  <= hoff_reg + hstep + 9'd1;
            end
            else
            begin
                hfrac_reg <= fsum[3:0];
                hoff_reg  <= hoff_reg + hstep;
            end
        end
    end

    assign status.setup_done = setup_done_reg;
    assign status.emit       = emit_c;
    assign status.last       = ({1'b0, idx_reg} + 4'd1) == n_reg;
    assign pix_index = idx_reg;
    assign pix_red   = r_reg;
    assign pix_green = g_reg;
    assign pix_blue  = b_reg;
endmodule
`default_nettype wire

// ===== design/lreg_controller.sv =====
// ----------------------------------------------------------------------------
// lreg_controller
// Sequences frame setup and per-pixel output beats.
// ----------------------------------------------------------------------------
`default_nettype none
module lreg_controller (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_fire,
    input  wire lreg_pkg::lreg_status_t status,
    input  wire logic                   out_ready,
    output lreg_pkg::lreg_cmd_t         cmd,
    output logic                        in_ready,
    output logic                        out_valid
);
    import lreg_pkg::*;
    `include "led_ring_effect_generator_macros.svh"

    typedef enum logic [2:0] {S_IDLE, S_SETUP, S_CHECK, S_PIX, S_OUT} state_t;
    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
        begin
            unique case (state_reg)
                S_IDLE:  if (in_fire) state_reg <= S_SETUP;
                S_SETUP: if (status.setup_done) state_reg <= S_CHECK;
                S_CHECK: state_reg <= status.emit ? S_PIX : S_IDLE;
                S_PIX:   state_reg <= S_OUT;
                S_OUT:
                    if (out_ready)
                        state_reg <= status.last ? S_IDLE : S_PIX;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready       = state_reg == S_IDLE;
    assign out_valid      = state_reg == S_OUT;
    assign cmd.start      = in_fire;
    assign cmd.setup_step = state_reg == S_SETUP && !status.setup_done;
    assign cmd.pix_step   = state_reg == S_PIX;
    assign cmd.pix_next   = state_reg == S_OUT && out_ready;

    `LREG_ASSERT_NEXT(a_out_after_pix, clk, rst_n, state_reg == S_PIX, out_valid)
    `LREG_ASSERT_IMP(a_no_accept_busy, clk, rst_n, in_fire, state_reg == S_IDLE)
    `LREG_ASSERT_NEXT(a_idle_after_last, clk, rst_n,
        out_valid && out_ready && status.last, in_ready)
endmodule
`default_nettype wire

// ===== design/led_ring_effect_generator.sv =====
// Each accepted input beat runs setup (gamma, reciprocal divide, 32-step remainder
// by ring size), then a check state, then for each pixel a compute state and an
// output beat state that waits for m_tready.
// One item in flight: no new input beat is accepted until the frame's last pixel
// beat is taken, or until the check finds that the frame emits nothing.
// Reset (rst_n, async low): mode solid, brightness 77, 8 pixels, color 0,
// frame counter 0.
`default_nettype none
module led_ring_effect_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // opcode[0], random_word[32:1]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // pixel_index[2:0], red, green, blue
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import lreg_pkg::*;

    lreg_cmd_t    cmd;
    lreg_status_t status;
    logic [2:0]   pidx;
    logic [7:0]   pr, pg, pb;
    logic         fire;

    assign fire = s_tvalid && s_tready;

    lreg_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(fire), .status(status),
        .out_ready(m_tready), .cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid)
    );

    lreg_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_en(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_opcode(s_tdata[0]), .in_random(s_tdata[32:1]),
        .cmd(cmd), .status(status), .pix_index(pidx),
        .pix_red(pr), .pix_green(pg), .pix_blue(pb)
    );

    // pack beat fields, pixel index lowest
    assign m_tdata = {5'd0, pb, pg, pr, pidx};
    assign m_tlast = status.last;
endmodule
`default_nettype wire

// ===== test/tb_led_ring_effect_generator.sv =====
// ----------------------------------------------------------------------------
// LED ring effect generator testbench
// Drives tick and apply beats through every effect mode and several register
// settings, predicts each frame of pixel beats, and checks them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_led_ring_effect_generator;
    import lreg_pkg::*;

    // One expected pixel beat
    typedef struct {
        logic [2:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_t;

    // Frame predictor and pixel scoreboard
    class ring_scoreboard;
        logic [3:0]  mode;
        logic [23:0] color;
        logic [8:0]  bright;
        logic [3:0]  count;
        logic [31:0] phase;
        pixel_t      pending[$];
        int          errors;
        int          frames;
        int          pixels_ok;

        function new();
            mode = MODE_SOLID;
            color = '0;
            bright = 9'd77;
            count = 4'd8;
            phase = '0;
            errors = 0;
            frames = 0;
            pixels_ok = 0;
        endfunction

        function int unsigned gamma(int unsigned c);
            longint unsigned b;
            b = (bright > 9'd256) ? 256 : bright;
            return int'((longint'(c) * b * b * b) >> 24);
        endfunction

        function void push(int unsigned i, int unsigned n, int unsigned r,
                           int unsigned g, int unsigned b);
            pixel_t p;
            p.idx = i[2:0];
            p.red = r[7:0];
            p.green = g[7:0];
            p.blue = b[7:0];
            p.last = (i + 1 == n);
            pending.push_back(p);
        endfunction

        // Render the frame that one accepted beat causes
        function void note_frame(logic op, logic [31:0] rnd);
            int unsigned n, cr, cg, cb, ph, i, s, head, per, st, d, v, hue;
            int unsigned reg_n, rem, q, t, r, g, b;
            logic lit;
            n = (count > MAX_PIXELS) ? MAX_PIXELS : 32'(count);
            cr = gamma(32'(color[23:16]));
            cg = gamma(32'(color[15:8]));
            cb = gamma(32'(color[7:0]));
            if (op == OP_APPLY)
                phase = '0;
            phase = phase + 1;
            ph = phase;
            frames++;
            if (n == 0)
                return;
            case (mode)
                MODE_OFF:
                begin
                    if (op == OP_APPLY)
                        for (i = 0; i < n; i++)
                            push(i, n, 0, 0, 0);
                end
                MODE_BREATHING:
                begin
                    s = ph % 60;
                    s = (s < 30) ? (s * 255 / 30) : ((59 - s) * 255 / 30);
                    for (i = 0; i < n; i++)
                        push(i, n, cr * s / 255, cg * s / 255, cb * s / 255);
                end
                MODE_CHASE:
                begin
                    head = (ph / 4) % n;
                    for (i = 0; i < n; i++)
                        if (i == head)
                            push(i, n, cr, cg, cb);
                        else
                            push(i, n, cr >> 3, cg >> 3, cb >> 3);
                end
                MODE_RAINBOW:
                begin
                    v = gamma(255);
                    for (i = 0; i < n; i++)
                    begin
                        hue = ((ph / 2) + (i * 256) / n) & 8'hFF;
                        reg_n = hue / 43;
                        rem = ((hue - reg_n * 43) * 6) & 8'hFF;
                        q = v * (255 - rem) / 255;
                        t = v * rem / 255;
                        case (reg_n)
                            0: begin r = v; g = t; b = 0; end
                            1: begin r = q; g = v; b = 0; end
                            2: begin r = 0; g = v; b = t; end
                            3: begin r = 0; g = q; b = v; end
                            4: begin r = t; g = 0; b = v; end
                            default: begin r = v; g = 0; b = q; end
                        endcase
                        push(i, n, r, g, b);
                    end
                end
                MODE_STROBE:
                begin
                    for (i = 0; i < n; i++)
                        if ((ph % 6) < 2)
                            push(i, n, cr, cg, cb);
                        else
                            push(i, n, 0, 0, 0);
                end
                MODE_SCANNER:
                begin
                    // a ring shorter than two LEDs has nowhere to sweep
                    if (n >= 2)
                    begin
                        per = 2 * (n - 1);
                        st = (ph / 3) % per;
                        head = (st < n) ? st : per - st;
                        for (i = 0; i < n; i++)
                        begin
                            d = (i > head) ? i - head : head - i;
                            if (d == 0)
                                push(i, n, cr, cg, cb);
                            else if (d == 1)
                                push(i, n, cr >> 2, cg >> 2, cb >> 2);
                            else
                                push(i, n, 0, 0, 0);
                        end
                    end
                end
                MODE_SPARKLE:
                begin
                    for (i = 0; i < n; i++)
                        if (((rnd >> (i * 4)) & 4'hF) < 2)
                            push(i, n, cr, cg, cb);
                        else
                            push(i, n, 0, 0, 0);
                end
                MODE_WIPE:
                begin
                    st = (ph / 4) % (2 * n);
                    for (i = 0; i < n; i++)
                    begin
                        lit = (st < n) ? (i <= st) : (i > st - n);
                        if (lit)
                            push(i, n, cr, cg, cb);
                        else
                            push(i, n, 0, 0, 0);
                    end
                end
                default:
                begin
                    // solid, and any undefined mode behaves as solid
                    if (op == OP_APPLY)
                        for (i = 0; i < n; i++)
                            push(i, n, cr, cg, cb);
                end
            endcase
        endfunction

        function void check_pixel(logic [31:0] data, logic last);
            pixel_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected pixel beat: data %h last %b", data, last);
                return;
            end
            e = pending.pop_front();
            if (data[2:0] !== e.idx || data[10:3] !== e.red || data[18:11] !== e.green
                || data[26:19] !== e.blue || last !== e.last)
            begin
                errors++;
                if (errors <= 10)
                    $display({"pixel mismatch: exp idx %0d rgb %h %h %h last %b, ",
                              "got idx %0d rgb %h %h %h last %b"},
                             e.idx, e.red, e.green, e.blue, e.last, data[2:0],
                             data[10:3], data[18:11], data[26:19], last);
            end
            else
                pixels_ok++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // opcode[0], random_word[32:1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // pixel_index[2:0], red[10:3], green[18:11], blue[26:19]
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    ring_scoreboard sb;
    int             burst_left;
    int             stall_mode = 0;
    int             stall_left = 0;
    int             cycles = 0;
    int             i;
    int             k;

    led_ring_effect_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: generous bound over the slowest legal run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: check pixel beats, stall on a pattern that changes every so often
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tlast);
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 80);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Write one register and mirror it in the predictor; block is idle here
    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:   sb.mode = value[3:0];
            REG_COLOR:  sb.color = value;
            REG_BRIGHT: sb.bright = value[8:0];
            default:    sb.count = value[3:0];
        endcase
    endtask

    task automatic set_all(logic [3:0] m, logic [23:0] c, logic [8:0] b, logic [3:0] n);
        write_reg(REG_MODE, {20'd0, m});
        write_reg(REG_COLOR, c);
        write_reg(REG_BRIGHT, {15'd0, b});
        write_reg(REG_COUNT, {20'd0, n});
    endtask

    // Send one beat; hold a burst, drop valid for a random gap between bursts
    task automatic send_beat(logic op, logic [31:0] rnd);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, rnd, op};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_frame(op, rnd);
    endtask

    // Wait until every expected pixel is in, then let a tick-only item finish
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Nibbles randomly forced to 0/1 so that sparkle lights some pixels
    function automatic logic [31:0] sparkle_word();
        logic [31:0] w;
        w = $urandom;
        for (int j = 0; j < 8; j++)
            if ($urandom_range(0, 1))
                w[j*4 +: 4] = {3'd0, w[j*4]};
        return w;
    endfunction

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, then every mode at full color and brightness
        send_beat(OP_APPLY, 32'h0);
        drain();
        set_all(MODE_OFF, 24'hFFFFFF, 9'd256, 4'd8);
        for (k = 0; k <= 9; k++)
        begin
            write_reg(REG_MODE, (k == 9) ? 24'd15 : k[23:0]);
            send_beat(OP_APPLY, 32'hFFFFFFFF);
            send_beat(OP_TICK, (k == MODE_SPARKLE) ? 32'h0 : 32'h10101010);
            drain();
        end
        // Saturating brightness and count, empty ring, single-LED scanner
        set_all(MODE_CHASE, 24'h00FF01, 9'd511, 4'd15);
        send_beat(OP_APPLY, 32'h0);
        drain();
        write_reg(REG_COUNT, 24'd0);
        send_beat(OP_APPLY, 32'h0);
        drain();
        set_all(MODE_SCANNER, 24'h80FE7F, 9'd0, 4'd1);
        send_beat(OP_APPLY, 32'h0);
        drain();

        // Random phases with fresh settings each time
        for (k = 0; k < 8; k++)
        begin
            case ($urandom_range(0, 3))
                0: set_all(4'($urandom_range(9, 15)), 24'($urandom), 9'($urandom),
                           4'($urandom));
                default: set_all(4'($urandom_range(0, 8)), 24'($urandom),
                                 ($urandom_range(0, 3) == 0) ? 9'd256 : 9'($urandom),
                                 ($urandom_range(0, 3) == 0) ? 4'd8 : 4'($urandom));
            endcase
            for (i = 0; i < 18; i++)
                send_beat(($urandom_range(0, 7) == 0 || i == 0) ? OP_APPLY : OP_TICK,
                          $urandom_range(0, 1) ? sparkle_word() : $urandom);
            drain();
        end

        if (sb.pending.size() != 0)
            sb.errors++;
        $display("covered %0d frames across all effect modes, %0d pixel beats matched",
                 sb.frames, sb.pixels_ok);
        $display("errors counted: %0d", sb.errors);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
